/* rtl/ecal_pkg.sv */
// Package: types, constants and helpers for the epoch-to-calendar converter.
`timescale 1ns / 1ps

package ecal_pkg;

    localparam int REM_W  = 32;
    localparam int Q_W    = 9;
    localparam int PC_W   = 4;

    localparam logic [REM_W-1:0] SECS_PER_YEAR = 32'd31536000;
    localparam logic [REM_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [REM_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [REM_W-1:0] SECS_PER_MIN  = 32'd60;
    localparam logic [11:0]      EPOCH_YEAR    = 12'd1970;
    localparam logic [1:0]       EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]       EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]       EPOCH_MOD400  = 9'd370;
    localparam logic [6:0]       LAST_MOD100   = 7'd99;
    localparam logic [8:0]       LAST_MOD400   = 9'd399;

    // Reciprocals of the odd parts of 86400, 3600 and 60 (675, 225, 15),
    // rounded up at 2^28, 2^21 and 2^14.
    localparam logic [18:0]      DAY_RECIP     = 19'd397683;
    localparam logic [13:0]      HOUR_RECIP    = 14'd9321;
    localparam logic [10:0]      MIN_RECIP     = 11'd1093;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_YEAR,
        OP_QUOT,
        OP_STORE,
        OP_MONTH,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        SEL_DAY,
        SEL_HOUR,
        SEL_MIN
    } sel_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_IN,
        COND_YEAR_MORE,
        COND_MONTH_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    typedef struct packed {
        logic year_more;
        logic month_more;
    } dp_status_t;

    localparam pc_t PC_IDLE    = 4'd0;
    localparam pc_t PC_YEAR    = 4'd1;
    localparam pc_t PC_DAYQ    = 4'd2;
    localparam pc_t PC_DAYST   = 4'd3;
    localparam pc_t PC_MONTH   = 4'd4;
    localparam pc_t PC_HOURQ   = 4'd5;
    localparam pc_t PC_HOURST  = 4'd6;
    localparam pc_t PC_MINQ    = 4'd7;
    localparam pc_t PC_MINST   = 4'd8;
    localparam pc_t PC_OUT     = 4'd9;
    localparam pc_t PC_RET     = 4'd10;

    function automatic logic [4:0] month_len(input logic [3:0] k, input logic leap);
        logic [4:0] ml;
        case (k)
            4'd1:                     ml = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  ml = 5'd30;
            default:                  ml = 5'd31;
        endcase
        return ml;
    endfunction

endpackage

/* rtl/ecal_ucode_rom.sv */
// Microcode ROM: one control word per sequencer step.
`timescale 1ns / 1ps

module ecal_ucode_rom (
    input  ecal_pkg::pc_t    pc,
    output ecal_pkg::ucode_t word
);
    import ecal_pkg::*;

    always_comb
    begin
        case (pc)
            PC_IDLE:   word = '{op: OP_LOAD,  sel: SEL_DAY,  cond: COND_NO_IN,      target: PC_IDLE};
            PC_YEAR:   word = '{op: OP_YEAR,  sel: SEL_DAY,  cond: COND_YEAR_MORE,  target: PC_YEAR};
            PC_DAYQ:   word = '{op: OP_QUOT,  sel: SEL_DAY,  cond: COND_NEXT,       target: PC_IDLE};
            PC_DAYST:  word = '{op: OP_STORE, sel: SEL_DAY,  cond: COND_NEXT,       target: PC_IDLE};
            PC_MONTH:  word = '{op: OP_MONTH, sel: SEL_DAY,  cond: COND_MONTH_MORE, target: PC_MONTH};
            PC_HOURQ:  word = '{op: OP_QUOT,  sel: SEL_HOUR, cond: COND_NEXT,       target: PC_IDLE};
            PC_HOURST: word = '{op: OP_STORE, sel: SEL_HOUR, cond: COND_NEXT,       target: PC_IDLE};
            PC_MINQ:   word = '{op: OP_QUOT,  sel: SEL_MIN,  cond: COND_NEXT,       target: PC_IDLE};
            PC_MINST:  word = '{op: OP_STORE, sel: SEL_MIN,  cond: COND_NEXT,       target: PC_IDLE};
            PC_OUT:    word = '{op: OP_OUT,   sel: SEL_DAY,  cond: COND_OUT_BUSY,   target: PC_OUT};
            PC_RET:    word = '{op: OP_NOP,   sel: SEL_DAY,  cond: COND_ALWAYS,     target: PC_IDLE};
            default:   word = '{op: OP_NOP,   sel: SEL_DAY,  cond: COND_ALWAYS,     target: PC_IDLE};
        endcase
    end

endmodule

/* rtl/ecal_datapath.sv */
// Datapath: year stepping, reciprocal-multiply day/hour/minute split and month walk.
`timescale 1ns / 1ps

module ecal_datapath (
    input  logic                   clk,
    input  ecal_pkg::ucode_t       word,
    input  logic                   exec,
    input  logic [31:0]            timestamp,
    output ecal_pkg::dp_status_t   status,
    output logic [11:0]            year,
    output logic [3:0]             month,
    output logic [4:0]             mday,
    output logic [4:0]             hour,
    output logic [5:0]             minute,
    output logic [5:0]             second
);
    import ecal_pkg::*;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [11:0]      year_reg, year_next;
    logic [1:0]       c4_reg, c4_next;
    logic [6:0]       c100_reg, c100_next;
    logic [8:0]       c400_reg, c400_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [8:0]       days_reg, days_next;
    logic [3:0]       mon_reg, mon_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       mday_reg, mday_next;
    logic [4:0]       hour_reg, hour_next;
    logic [5:0]       minute_reg, minute_next;

    logic             leap;
    logic [REM_W-1:0] year_len;
    logic [4:0]       ml;
    logic [36:0]      day_prod;
    logic [26:0]      hour_prod;
    logic [20:0]      min_prod;
    logic [REM_W-1:0] q_ext;

    assign leap     = ((c4_reg == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign year_len = leap ? (SECS_PER_YEAR + SECS_PER_DAY) : SECS_PER_YEAR;
    assign ml       = month_len(mon_reg, leap);

    // rem < 366 days, < 1 day, < 1 hour at the respective split
    assign day_prod  = {19'd0, rem_reg[24:7]} * {18'd0, DAY_RECIP};
    assign hour_prod = {14'd0, rem_reg[16:4]} * {13'd0, HOUR_RECIP};
    assign min_prod  = {11'd0, rem_reg[11:2]} * {10'd0, MIN_RECIP};
    assign q_ext     = {{(REM_W-Q_W){1'b0}}, q_reg};

    assign status.year_more  = rem_reg >= year_len;
    assign status.month_more = days_reg >= {4'd0, ml};

    always_comb
    begin
        rem_next    = rem_reg;
        year_next   = year_reg;
        c4_next     = c4_reg;
        c100_next   = c100_reg;
        c400_next   = c400_reg;
        q_next      = q_reg;
        days_next   = days_reg;
        mon_next    = mon_reg;
        month_next  = month_reg;
        mday_next   = mday_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        if (exec)
        begin
            case (word.op)
                OP_LOAD:
                begin
                    rem_next  = timestamp;
                    year_next = EPOCH_YEAR;
                    c4_next   = EPOCH_MOD4;
                    c100_next = EPOCH_MOD100;
                    c400_next = EPOCH_MOD400;
                    mon_next  = 4'd0;
                end
                OP_YEAR:
                begin
                    if (status.year_more)
                    begin
                        rem_next  = rem_reg - year_len;
                        year_next = year_reg + 12'd1;
                        c4_next   = c4_reg + 2'd1;
                        c100_next = (c100_reg == LAST_MOD100) ? 7'd0 : c100_reg + 7'd1;
                        c400_next = (c400_reg == LAST_MOD400) ? 9'd0 : c400_reg + 9'd1;
                    end
                end
                OP_QUOT:
                begin
                    case (word.sel)
                        SEL_DAY:  q_next = day_prod[36:28];
                        SEL_HOUR: q_next = {4'd0, hour_prod[25:21]};
                        SEL_MIN:  q_next = {3'd0, min_prod[19:14]};
                        default:  q_next = q_reg;
                    endcase
                end
                OP_STORE:
                begin
                    case (word.sel)
                        SEL_DAY:
                        begin
                            days_next = q_reg;
                            rem_next  = rem_reg - q_ext * SECS_PER_DAY;
                        end
                        SEL_HOUR:
                        begin
                            hour_next = q_reg[4:0];
                            rem_next  = rem_reg - q_ext * SECS_PER_HOUR;
                        end
                        SEL_MIN:
                        begin
                            minute_next = q_reg[5:0];
                            rem_next    = rem_reg - q_ext * SECS_PER_MIN;
                        end
                        default:  days_next = days_reg;
                    endcase
                end
                OP_MONTH:
                begin
                    if (status.month_more)
                    begin
                        days_next = days_reg - {4'd0, ml};
                        mon_next  = mon_reg + 4'd1;
                    end
                    else
                    begin
                        month_next = mon_reg + 4'd1;
                        mday_next  = days_reg[4:0] + 5'd1;
                    end
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        year_reg   <= year_next;
        c4_reg     <= c4_next;
        c100_reg   <= c100_next;
        c400_reg   <= c400_next;
        q_reg      <= q_next;
        days_reg   <= days_next;
        mon_reg    <= mon_next;
        month_reg  <= month_next;
        mday_reg   <= mday_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
    end

    assign year   = year_reg;
    assign month  = month_reg;
    assign mday   = mday_reg;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = rem_reg[5:0];

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// Top level: microcode sequencer, output register and checks for epoch-to-calendar.
//
//  channel | signals                                       | dir | notes
//  --------+-----------------------------------------------+-----+------------------------
//  ts      | ts_valid, ts_ready, timestamp                 | in  | one 32-bit timestamp
//  cal     | cal_valid, cal_ready, year_out, month_out,    | out | one date/time per input
//          | day_out, hour_out, minute_out, second_out     |     |
//
// Years are stepped one per cycle and months walked one per cycle; the day, hour and minute
// splits take two steps each, a quotient step and a store step.
// The result becomes valid when the output step loads the output register.
// rst_n clears the step counter and the output valid; datapath registers are not reset.
// A finished result sits in the output register; the next timestamp is taken meanwhile,
// and the sequencer holds at its output step only while that register is still full.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ts_valid,
    output logic        ts_ready,
    input  logic [31:0] timestamp,
    output logic        cal_valid,
    input  logic        cal_ready,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out
);
    import ecal_pkg::*;

    pc_t        pc_reg, pc_next;
    ucode_t     word;
    dp_status_t status;
    logic       exec;
    logic       busy;
    logic       cond_true;
    logic       out_load;
    logic       cal_valid_reg, cal_valid_next;

    logic [11:0] dp_year;
    logic [3:0]  dp_month;
    logic [4:0]  dp_mday;
    logic [4:0]  dp_hour;
    logic [5:0]  dp_minute;
    logic [5:0]  dp_second;

    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;

    ecal_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    ecal_datapath u_dp (
        .clk       (clk),
        .word      (word),
        .exec      (exec),
        .timestamp (timestamp),
        .status    (status),
        .year      (dp_year),
        .month     (dp_month),
        .mday      (dp_mday),
        .hour      (dp_hour),
        .minute    (dp_minute),
        .second    (dp_second)
    );

    assign busy     = cal_valid_reg && !cal_ready;
    assign ts_ready = (word.op == OP_LOAD);
    assign out_load = (word.op == OP_OUT) && !busy;

    always_comb
    begin
        case (word.op)
            OP_LOAD: exec = ts_valid;
            OP_OUT:  exec = !busy;
            default: exec = 1'b1;
        endcase
    end

    always_comb
    begin
        case (word.cond)
            COND_NEXT:       cond_true = 1'b0;
            COND_ALWAYS:     cond_true = 1'b1;
            COND_NO_IN:      cond_true = !ts_valid;
            COND_YEAR_MORE:  cond_true = status.year_more;
            COND_MONTH_MORE: cond_true = status.month_more;
            COND_OUT_BUSY:   cond_true = busy;
            default:         cond_true = 1'b0;
        endcase
        pc_next = cond_true ? word.target : pc_reg + 4'd1;
    end

    always_comb
    begin
        cal_valid_next = cal_valid_reg;
        if (out_load)
        begin
            cal_valid_next = 1'b1;
        end
        else if (cal_ready)
        begin
            cal_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            cal_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cal_valid_reg <= cal_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            year_reg   <= dp_year;
            month_reg  <= dp_month;
            day_reg    <= dp_mday;
            hour_reg   <= dp_hour;
            minute_reg <= dp_minute;
            second_reg <= dp_second;
        end
    end

    assign cal_valid  = cal_valid_reg;
    assign year_out   = year_reg;
    assign month_out  = month_reg;
    assign day_out    = day_reg;
    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;
    assign second_out = second_reg;

    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1)
                      && (hour_out <= 5'd23) && (minute_out <= 6'd59) && (second_out <= 6'd59))
        else $error("calendar field out of range");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (year_out >= 12'd1970) && (year_out <= 12'd2106))
        else $error("year out of range");

    a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cal_valid && (month_out == 4'd2)) |-> (day_out <= 5'd29))
        else $error("february day beyond 29");

    a_accept_starts_year: assert property (@(posedge clk) disable iff (!rst_n)
        (ts_valid && ts_ready) |=> (pc_reg == PC_YEAR) && !ts_ready)
        else $error("accepted transaction did not start the year loop");

endmodule

/* verif/testbench.sv */
// Testbench for epoch_seconds_to_calendar: random and directed timestamps, scoreboard check.
`timescale 1ns / 1ps

module testbench;

    localparam int           N_RANDOM    = 1726;
    localparam int           CYCLE_LIMIT = 2000000;
    localparam int           DRAIN_WAIT  = 250;
    localparam int           HOLD_CYCLES = 800;
    localparam int           HOLD_AFTER  = 400;
    localparam int           PAUSE_AT    = 900;
    localparam int unsigned  EPOCH       = 1970;
    localparam longint unsigned DAY_SECS  = 86400;
    localparam longint unsigned YEAR_SECS = 31536000;

    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    class date_board;
        cal_t expected_dates[$];
        int   errors;
        int   accepted;

        function new();
            errors   = 0;
            accepted = 0;
        endfunction

        static function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned days_in_month(int unsigned y, int unsigned m);
            case (m)
                2:           return is_leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        static function cal_t to_calendar(logic [31:0] ts);
            longint unsigned t;
            longint unsigned start;
            longint unsigned span;
            longint unsigned rem;
            longint unsigned days;
            int unsigned     y;
            int unsigned     m;
            bit              found;
            cal_t            c;
            t     = ts;
            start = 0;
            y     = EPOCH;
            span  = YEAR_SECS;
            while (start + span <= t) begin
                start += span;
                y++;
                span = YEAR_SECS + (is_leap(y) ? DAY_SECS : 0);
            end
            if (is_leap(EPOCH) && y == EPOCH) span = YEAR_SECS + DAY_SECS;
            rem  = t - start;
            days = rem / DAY_SECS;
            rem  = rem % DAY_SECS;
            c.month = 4'd12;
            c.day   = 5'd1;
            found   = 0;
            for (m = 1; m <= 12; m++) begin
                if (!found) begin
                    if (days < days_in_month(y, m)) begin
                        c.month = m[3:0];
                        c.day   = 5'(days + 1);
                        found   = 1;
                    end else begin
                        days -= days_in_month(y, m);
                    end
                end
            end
            c.year   = y[11:0];
            c.hour   = 5'(rem / 3600);
            c.minute = 6'((rem % 3600) / 60);
            c.second = 6'(rem % 60);
            return c;
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected_dates.size();
        endfunction

        function void log_timestamp(logic [31:0] ts);
            expected_dates.push_back(to_calendar(ts));
            accepted++;
        endfunction

        task check_date(cal_t got);
            cal_t exp_d;
            if (expected_dates.size() == 0) begin
                report("result with no transaction outstanding");
            end else begin
                exp_d = expected_dates.pop_front();
                if (got.year !== exp_d.year)
                    report($sformatf("year %0d, expected %0d", got.year, exp_d.year));
                if (got.month !== exp_d.month)
                    report($sformatf("month %0d, expected %0d", got.month, exp_d.month));
                if (got.day !== exp_d.day)
                    report($sformatf("day %0d, expected %0d", got.day, exp_d.day));
                if (got.hour !== exp_d.hour)
                    report($sformatf("hour %0d, expected %0d", got.hour, exp_d.hour));
                if (got.minute !== exp_d.minute)
                    report($sformatf("minute %0d, expected %0d", got.minute, exp_d.minute));
                if (got.second !== exp_d.second)
                    report($sformatf("second %0d, expected %0d", got.second, exp_d.second));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        ts_valid;
    logic        ts_ready;
    logic [31:0] timestamp;
    logic        cal_valid;
    logic        cal_ready;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;

    date_board   sb;
    int          cycles;
    logic [31:0] directed_ts [24];

    epoch_seconds_to_calendar u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .ts_valid   (ts_valid),
        .ts_ready   (ts_ready),
        .timestamp  (timestamp),
        .cal_valid  (cal_valid),
        .cal_ready  (cal_ready),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .hour_out   (hour_out),
        .minute_out (minute_out),
        .second_out (second_out)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n     = 1'b0;
        ts_valid  = 1'b0;
        timestamp = '0;
        cal_ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint unsigned secs_at(int unsigned y, int unsigned m, int unsigned d);
        longint unsigned s;
        int unsigned     i;
        s = 0;
        for (i = EPOCH; i < y; i++)
            s += YEAR_SECS + (date_board::is_leap(i) ? DAY_SECS : 0);
        for (i = 1; i < m; i++)
            s += date_board::days_in_month(y, i) * DAY_SECS;
        return s + (d - 1) * DAY_SECS;
    endfunction

    // year and month starts with small offsets, hour edges, the top of range, plain noise
    function automatic logic [31:0] pick_timestamp();
        int unsigned     kind;
        int unsigned     y;
        int unsigned     m;
        int unsigned     d;
        longint unsigned base;
        logic [31:0]     v;
        kind = $urandom_range(0, 9);
        y    = $urandom_range(1970, 2105);
        m    = $urandom_range(1, 12);
        d    = $urandom_range(1, date_board::days_in_month(y, m));
        case (kind)
            4, 5: begin
                base = secs_at(y, 1, 1);
                v    = base[31:0] + 32'($urandom_range(0, 4)) - 32'd2;
            end
            6, 7: begin
                base = secs_at(y, m, 1);
                v    = base[31:0] + 32'($urandom_range(0, 4)) - 32'd2;
            end
            8: begin
                base = secs_at(y, m, d) + $urandom_range(0, 23) * 3600;
                v    = base[31:0] + 32'($urandom_range(0, 120)) - 32'd60;
            end
            9:       v = 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task send_timestamp(input logic [31:0] v, input int gap);
        repeat (gap) begin
            @(negedge clk);
            ts_valid  <= 1'b0;
            timestamp <= $urandom;
        end
        @(negedge clk);
        ts_valid  <= 1'b1;
        timestamp <= v;
        do @(posedge clk); while (!ts_ready);
        sb.log_timestamp(v);
    endtask

    always @(posedge clk)
    begin : cal_monitor
        cal_t got;
        if (rst_n && cal_valid && cal_ready) begin
            got.year   = year_out;
            got.month  = month_out;
            got.day    = day_out;
            got.hour   = hour_out;
            got.minute = minute_out;
            got.second = second_out;
            sb.check_date(got);
        end
    end

    initial
    begin : cal_sink
        int stall;
        int n;
        bit held;
        stall = 0;
        n     = 0;
        held  = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            n++;
            if (!held && sb.accepted >= HOLD_AFTER) begin
                held  = 1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                cal_ready <= 1'b0;
                stall--;
            end else begin
                cal_ready <= 1'b1;
                stall = pick_gap((n / 3000) % 3 == 1);
            end
        end
    end

    initial
    begin : ts_source
        int i;
        sb     = new();
        cycles = 0;
        directed_ts = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                        32'd86400, 32'd31535999, 32'd31536000, 32'd68169600,
                        32'd94694399, 32'd946684799, 32'd951782400, 32'd951868800,
                        32'd4102444800, 32'd4107542399, 32'd4107542400,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 24; i++)
            send_timestamp(directed_ts[i], pick_gap(0));

        for (i = 0; i < N_RANDOM; i++) begin
            if (i == PAUSE_AT) begin
                @(negedge clk);
                ts_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
            end
            send_timestamp(pick_timestamp(), pick_gap((i / 150) % 4 == 1));
        end
        @(negedge clk);
        ts_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* epoch_seconds_to_calendar.f */
rtl/ecal_pkg.sv
rtl/ecal_ucode_rom.sv
rtl/ecal_datapath.sv
rtl/epoch_seconds_to_calendar.sv
verif/testbench.sv
